[rtl/idiv_pkg.sv]
package idiv_pkg;

  // Operand and result width, and the width of the narrow modes.
  localparam int unsigned XLEN  = 64;
  localparam int unsigned WLEN  = 32;
  // One quotient bit per step stage.
  localparam int unsigned NSTEP = XLEN;

  typedef enum logic [1:0] {
    ACT_U64 = 2'd0,
    ACT_U32 = 2'd1,
    ACT_S64 = 2'd2,
    ACT_S32 = 2'd3
  } action_e;

  // Control that travels beside the data through every stage.
  typedef struct packed {
    logic neg;   // negate the magnitude quotient at the end
    logic zero;  // divisor was zero: force the quotient to zero
    logic sext;  // sign-extend from the narrow width
  } ctl_t;

  // rem: partial remainder; dq: dividend bits still to shift out at the top,
  // quotient bits shifting in at the bottom; dvs: divisor magnitude.
  typedef struct packed {
    ctl_t            ctl;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] dq;
    logic [XLEN-1:0] dvs;
  } work_t;

endpackage

[rtl/idiv_req_if.sv]
interface idiv_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [idiv_pkg::XLEN-1:0]  dividend;
  logic [idiv_pkg::XLEN-1:0]  divisor;

  modport source (output valid, output action, output dividend, output divisor, input ready);
  modport sink   (input valid, input action, input dividend, input divisor, output ready);
endinterface

[rtl/idiv_rsp_if.sv]
interface idiv_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [idiv_pkg::XLEN-1:0]  quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

[rtl/idiv_pre.sv]
module idiv_pre (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [1:0]                action_i,
  input  logic [idiv_pkg::XLEN-1:0] dividend_i,
  input  logic [idiv_pkg::XLEN-1:0] divisor_i,
  output logic                      valid_o,
  output idiv_pkg::work_t           data_o
);

  localparam int unsigned W = idiv_pkg::XLEN;
  localparam int unsigned H = idiv_pkg::WLEN;

  idiv_pkg::action_e act;
  logic              is32;
  logic              sgn;
  logic [W-1:0]      a;
  logic [W-1:0]      b;
  logic [W-1:0]      neg_a;
  logic [W-1:0]      neg_b;
  logic              na;
  logic              nb;
  idiv_pkg::work_t   data_d;
  idiv_pkg::work_t   data_q;
  logic              valid_q;

  always_comb begin
    act = idiv_pkg::action_e'(action_i);
    unique case (act)
      idiv_pkg::ACT_U64: begin is32 = 1'b0; sgn = 1'b0; end
      idiv_pkg::ACT_U32: begin is32 = 1'b1; sgn = 1'b0; end
      idiv_pkg::ACT_S64: begin is32 = 1'b0; sgn = 1'b1; end
      idiv_pkg::ACT_S32: begin is32 = 1'b1; sgn = 1'b1; end
      default:           begin is32 = 1'b0; sgn = 1'b0; end
    endcase

    // Narrow modes see only the low half, zero-extended.
    a = is32 ? {{(W-H){1'b0}}, dividend_i[H-1:0]} : dividend_i;
    b = is32 ? {{(W-H){1'b0}}, divisor_i[H-1:0]}  : divisor_i;
    neg_a = '0 - a;
    neg_b = '0 - b;
    na = sgn && (is32 ? a[H-1] : a[W-1]);
    nb = sgn && (is32 ? b[H-1] : b[W-1]);

    data_d.ctl.neg  = na ^ nb;
    data_d.ctl.zero = (b == '0);
    data_d.ctl.sext = is32 && sgn;
    data_d.rem      = '0;
    data_d.dq       = na ? (is32 ? {{(W-H){1'b0}}, neg_a[H-1:0]} : neg_a) : a;
    data_d.dvs      = nb ? (is32 ? {{(W-H){1'b0}}, neg_b[H-1:0]} : neg_b) : b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/idiv_step.sv]
module idiv_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  idiv_pkg::work_t data_i,
  output logic            valid_o,
  output idiv_pkg::work_t data_o
);

  localparam int unsigned W = idiv_pkg::XLEN;

  logic [W:0]      trial;
  logic [W+1:0]    diff;
  logic            ge;
  idiv_pkg::work_t data_d;
  idiv_pkg::work_t data_q;
  logic            valid_q;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial  = {data_i.rem, data_i.dq[W-1]};
    diff   = {1'b0, trial} - {2'b00, data_i.dvs};
    ge     = !diff[W+1];
    data_d = data_i;
    data_d.rem = ge ? diff[W-1:0] : trial[W-1:0];
    data_d.dq  = {data_i.dq[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // The partial remainder always stays below a non-zero divisor.
  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (data_q.dvs != '0) |-> data_q.rem < data_q.dvs)
    else $error("partial remainder not below divisor");

endmodule

[rtl/idiv_post.sv]
module idiv_post (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  idiv_pkg::work_t           data_i,
  output logic                      valid_o,
  output logic [idiv_pkg::XLEN-1:0] quotient_o
);

  localparam int unsigned W = idiv_pkg::XLEN;
  localparam int unsigned H = idiv_pkg::WLEN;

  logic [W-1:0] mag_q_n;
  logic [W-1:0] quot_d;
  logic [W-1:0] quot_q;
  logic         valid_q;

  always_comb begin
    mag_q_n = data_i.ctl.neg ? ('0 - data_i.dq) : data_i.dq;
    if (data_i.ctl.zero) begin
      quot_d = '0;
    end else if (data_i.ctl.sext) begin
      quot_d = {{(W-H){mag_q_n[H-1]}}, mag_q_n[H-1:0]};
    end else begin
      quot_d = mag_q_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      quot_q <= quot_d;
    end
  end

  assign valid_o    = valid_q;
  assign quotient_o = quot_q;

  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i && data_i.ctl.zero |=> quot_q == '0)
    else $error("divide by zero did not give zero");

  a_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i && data_i.ctl.sext |=> quot_q[W-1:H] == {(W-H){quot_q[H-1]}})
    else $error("narrow signed quotient not sign-extended");

endmodule

[rtl/integer_divider_32_64.sv]
// Channel  Role    Transaction            Payload
// -------  ------  ---------------------  ---------------------------------
// req_i    sink    valid & ready high     action[1:0], dividend, divisor
// rsp_o    source  valid & ready high     quotient
//
// Throughput: one transaction per cycle while rsp_o is not stalled. Pipeline:
// one operand-conditioning stage, 64 restoring-division stages that each settle
// one quotient bit with a 65-bit subtract, and one sign-fix stage.
// Reset: rst_ni clears every stage valid bit asynchronously; payload
// registers carry no reset.
// Stalls: while the result register holds a transaction that is not taken,
// every stage holds and req_i.ready is low; nothing is dropped or repeated.
module integer_divider_32_64 (
  input  logic     clk_i,
  input  logic     rst_ni,
  idiv_req_if.sink   req_i,
  idiv_rsp_if.source rsp_o
);

  localparam int unsigned NSTEP = idiv_pkg::NSTEP;

  // Stage 0 is the conditioning stage, stage k+1 the output of step k.
  logic [NSTEP:0]  pipe_valid;
  idiv_pkg::work_t pipe_data [NSTEP+1];
  logic            out_valid;
  logic            pipe_en;

  // Advance the whole pipe whenever the result register is free or drained.
  assign pipe_en     = !out_valid || rsp_o.ready;
  assign req_i.ready = pipe_en;

  // Take absolute values, flag divide by zero and note the sign of the result.
  idiv_pre u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (req_i.valid),
    .action_i   (req_i.action),
    .dividend_i (req_i.dividend),
    .divisor_i  (req_i.divisor),
    .valid_o    (pipe_valid[0]),
    .data_o     (pipe_data[0])
  );

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    idiv_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (pipe_valid[k]),
      .data_i  (pipe_data[k]),
      .valid_o (pipe_valid[k+1]),
      .data_o  (pipe_data[k+1])
    );
  end

  // Restore the sign, extend narrow results, force zero on a zero divisor.
  idiv_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (pipe_valid[NSTEP]),
    .data_i     (pipe_data[NSTEP]),
    .valid_o    (out_valid),
    .quotient_o (rsp_o.quotient)
  );

  assign rsp_o.valid = out_valid;

  // A held pipe keeps every transaction where it is.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(pipe_valid) && out_valid)
    else $error("pipeline moved while stalled");

endmodule
